// File: sv/aac_pkg.sv
// Shared types, codes and constants for the AIMD admission controller.
package aac_pkg;

	localparam int DEF_MAX_WAITERS = 1024;
	localparam int DEF_CAP_WIDTH   = 16;

	localparam int ACTION_W  = 3;
	localparam int UNITS_W   = 32;
	localparam int FIELD_W   = 16;
	localparam int WAKE_W    = 11;
	localparam int FACTOR_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [FIELD_W-1:0]  RST_DEFAULT_CAP = 16'd20;
	localparam logic [FIELD_W-1:0]  RST_MIN_FLOOR   = 16'd1;
	localparam logic [FACTOR_W-1:0] RST_FACTOR      = 16'd32768;
	localparam logic [FACTOR_W-1:0] FACTOR_LO       = 16'd655;
	localparam logic [FACTOR_W-1:0] FACTOR_HI       = 16'd64880;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ACQUIRE  = 3'd0,
		ACT_RELEASE  = 3'd1,
		ACT_WAIT     = 3'd2,
		ACT_OVERLOAD = 3'd3,
		ACT_SUCCESS  = 3'd4,
		ACT_STATUS   = 3'd5
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CEILING  = 3'd0,
		REG_DEFAULT  = 3'd1,
		REG_FLOOR    = 3'd2,
		REG_ADAPTIVE = 3'd3,
		REG_FACTOR   = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ITER,
		ST_ADAPT,
		ST_CAP,
		ST_DONE
	} state_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_req_t;

endpackage

// File: sv/aac_iter_unit.sv
// Bit-serial shift-add multiplier and restoring divider sharing one adder.
module aac_iter_unit #(
	parameter int CAP_WIDTH = aac_pkg::DEF_CAP_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  aac_pkg::unit_req_t          req,
	input  logic [aac_pkg::UNITS_W-1:0] opa,
	input  logic [CAP_WIDTH-1:0]        opb,
	output logic                        done,
	output logic [CAP_WIDTH-1:0]        prod_hi,
	output logic [aac_pkg::UNITS_W-1:0] quot
);
	import aac_pkg::*;

	localparam int CW        = CAP_WIDTH;
	localparam int DIV_STEPS = UNITS_W;
	localparam int MUL_STEPS = FACTOR_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	logic [CW-1:0]      hi_q;
	logic [UNITS_W-1:0] lo_q;
	logic [CW-1:0]      b_q;
	logic [CNT_W-1:0]   cnt_q;
	unit_op_t           op_q;
	logic               busy_q;
	logic               done_q;

	logic [CW:0]        a_op;
	logic [CW:0]        b_op;
	logic               sub;
	logic [CW+1:0]      sum;
	logic [CW-1:0]      hi_n;
	logic [UNITS_W-1:0] lo_n;

	always_comb begin
		if (op_q == OP_DIV) begin
			a_op = {hi_q, lo_q[UNITS_W-1]};
			b_op = {1'b0, b_q};
			sub  = 1'b1;
		end else begin
			a_op = {1'b0, hi_q};
			b_op = lo_q[0] ? {1'b0, b_q} : '0;
			sub  = 1'b0;
		end
		sum = {1'b0, a_op} + {1'b0, (sub ? ~b_op : b_op)} + (CW+2)'(sub);
		if (op_q == OP_DIV) begin
			// carry out means no borrow: divisor fits, quotient bit is 1
			hi_n = sum[CW+1] ? sum[CW-1:0] : a_op[CW-1:0];
			lo_n = {lo_q[UNITS_W-2:0], sum[CW+1]};
		end else begin
			hi_n = sum[CW:1];
			lo_n = {sum[0], lo_q[UNITS_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == OP_DIV) ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q <= '0;
			lo_q <= opa;
			b_q  <= opb;
		end else if (busy_q) begin
			hi_q <= hi_n;
			lo_q <= lo_n;
		end
	end

	assign done    = done_q;
	assign prod_hi = hi_q;
	assign quot    = lo_q;

endmodule

// File: sv/aimd_admission_controller_core.sv
// AIMD admission controller: top level with sequencer, state and output register.
// Acquire, release, wait, status and non-adapting words pass ST_ADAPT, ST_CAP and ST_DONE;
// an adaptive overload first runs a 16-step multiply, a growing success a 32-step divide.
// One word at a time: the next word waits until the result is registered.
// Reset: arst_n clears all counters, the adapted capacity and the low-water mark, and loads
// the register defaults (ceiling 0, default capacity 20, floor 1, adaptation off, factor 0.5).
module aimd_admission_controller_core #(
	parameter int MAX_WAITERS = aac_pkg::DEF_MAX_WAITERS,
	parameter int CAP_WIDTH   = aac_pkg::DEF_CAP_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aac_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [aac_pkg::ACTION_W-1:0]  action,
	input  logic [aac_pkg::UNITS_W-1:0]   units,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          admitted,
	output logic                          queue_full,
	output logic [aac_pkg::WAKE_W-1:0]    wake_count,
	output logic [aac_pkg::FIELD_W-1:0]   capacity_now,
	output logic [aac_pkg::FIELD_W-1:0]   pending_now,
	output logic [aac_pkg::FIELD_W-1:0]   peak_pending,
	output logic [aac_pkg::FIELD_W-1:0]   low_water,
	output logic [aac_pkg::FIELD_W-1:0]   available
);
	import aac_pkg::*;

	localparam int CW     = CAP_WIDTH;
	localparam int WW     = $clog2(MAX_WAITERS + 1);
	localparam int HW     = (CW > WW) ? CW : WW;
	localparam int SW     = UNITS_W + 1;

	// configuration
	logic [CW-1:0]       ceiling_q;
	logic [CW-1:0]       default_q;
	logic [CW-1:0]       floor_q;
	logic                adaptive_q;
	logic [FACTOR_W-1:0] factor_q;

	// limiter state
	logic [CW-1:0] adapted_q;
	logic [CW-1:0] pending_q;
	logic [CW-1:0] peak_q;
	logic [CW-1:0] lw_q;
	logic [WW-1:0] waiter_q;

	// sequencer
	state_t               state_q, state_n;
	logic [ACTION_W-1:0]  action_q;
	logic                 go_q;
	logic [CW-1:0]        cap_q;

	logic                 accept;
	logic                 need_unit;
	logic                 out_free;
	logic                 load_out;
	unit_req_t            ureq;
	logic [UNITS_W-1:0]   uopa;
	logic [CW-1:0]        uopb;
	logic                 udone;
	logic [CW-1:0]        prod_hi;
	logic [UNITS_W-1:0]   quot;

	logic [CW-1:0]        ceil_c;
	logic [CW-1:0]        floor_c;
	logic [CW-1:0]        cap_c;
	logic [CW-1:0]        cur_c;

	logic [CW-1:0]        ov_nxt;
	logic [UNITS_W-1:0]   step_c;
	logic [SW-1:0]        gr_nxt;

	logic [CW-1:0]        pend_n;
	logic [CW-1:0]        peak_n;
	logic [WW-1:0]        waiter_n;
	logic [WW-1:0]        wake_n;
	logic                 adm_n;
	logic                 qfull_n;
	logic [CW-1:0]        head_c;
	logic [CW-1:0]        avail_c;

	// effective ceiling, floor and capacity
	always_comb begin
		ceil_c = (ceiling_q != '0) ? ceiling_q : default_q;
		if (ceil_c == '0)
			ceil_c = CW'(1);
		floor_c = (floor_q == '0) ? CW'(1) : floor_q;
		if (floor_c > ceil_c)
			floor_c = ceil_c;
		if (!adaptive_q || adapted_q == '0)
			cap_c = ceil_c;
		else if (adapted_q < floor_c)
			cap_c = floor_c;
		else if (adapted_q > ceil_c)
			cap_c = ceil_c;
		else
			cap_c = adapted_q;
		cur_c = (adapted_q != '0) ? adapted_q : ceil_c;
	end

	// sequencer decisions
	always_comb begin
		need_unit = 1'b0;
		case (action_t'(action))
			ACT_OVERLOAD: need_unit = adaptive_q;
			ACT_SUCCESS:  need_unit = (units != '0) && adaptive_q && (adapted_q != '0);
			default:      need_unit = 1'b0;
		endcase
	end

	assign out_free = !out_valid || !out_stall;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_n = need_unit ? ST_ITER : ST_ADAPT;
			ST_ITER:  if (udone) state_n = ST_ADAPT;
			ST_ADAPT: state_n = ST_CAP;
			ST_CAP:   state_n = ST_DONE;
			ST_DONE:  if (out_free) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		accept     = in_valid && (state_q == ST_IDLE);
		load_out   = (state_q == ST_DONE) && out_free;
		ureq.start = accept && need_unit;
		ureq.op    = (action_t'(action) == ACT_SUCCESS) ? OP_DIV : OP_MUL;
		uopa       = (action_t'(action) == ACT_SUCCESS) ? units : UNITS_W'(factor_q);
		uopb       = (action_t'(action) == ACT_SUCCESS) ? adapted_q : cur_c;
	end

	aac_iter_unit #(
		.CAP_WIDTH (CAP_WIDTH)
	) u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ureq),
		.opa     (uopa),
		.opb     (uopb),
		.done    (udone),
		.prod_hi (prod_hi),
		.quot    (quot)
	);

	// adaptation: multiplicative decrease and additive increase
	always_comb begin
		ov_nxt = prod_hi;
		if (ov_nxt < floor_c)
			ov_nxt = floor_c;
		if (ov_nxt > ceil_c)
			ov_nxt = ceil_c;
		step_c = (quot == '0) ? UNITS_W'(1) : quot;
		gr_nxt = SW'(adapted_q) + SW'(step_c);
	end

	// counter updates against the registered capacity
	always_comb begin
		pend_n   = pending_q;
		peak_n   = peak_q;
		waiter_n = waiter_q;
		wake_n   = '0;
		adm_n    = 1'b0;
		qfull_n  = 1'b0;
		head_c   = (cap_q > pending_q) ? (cap_q - pending_q) : '0;
		case (action_t'(action_q))
			ACT_ACQUIRE: begin
				if (pending_q != '1)
					pend_n = pending_q + 1'b1;
				if (pend_n > peak_q)
					peak_n = pend_n;
			end
			ACT_RELEASE: begin
				if (pending_q != '0)
					pend_n = pending_q - 1'b1;
				if (pend_n < cap_q && waiter_q != '0) begin
					waiter_n = waiter_q - 1'b1;
					wake_n   = WW'(1);
				end
			end
			ACT_WAIT: begin
				if (pending_q < cap_q)
					adm_n = 1'b1;
				else if (waiter_q < WW'(MAX_WAITERS))
					waiter_n = waiter_q + 1'b1;
				else
					qfull_n = 1'b1;
			end
			ACT_SUCCESS: begin
				if (go_q) begin
					// wake up to the headroom, bounded by the parked count
					wake_n   = (HW'(head_c) < HW'(waiter_q)) ? WW'(head_c) : waiter_q;
					waiter_n = waiter_q - wake_n;
				end
			end
			default: begin
			end
		endcase
		avail_c = (cap_q > pend_n) ? (cap_q - pend_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q  <= '0;
			default_q  <= CW'(RST_DEFAULT_CAP);
			floor_q    <= CW'(RST_MIN_FLOOR);
			adaptive_q <= 1'b0;
			factor_q   <= RST_FACTOR;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CEILING:  ceiling_q  <= CW'(cfg_data);
				REG_DEFAULT:  default_q  <= CW'(cfg_data);
				REG_FLOOR:    floor_q    <= CW'(cfg_data);
				REG_ADAPTIVE: adaptive_q <= cfg_data[0];
				REG_FACTOR: begin
					if (cfg_data < FACTOR_LO)
						factor_q <= FACTOR_LO;
					else if (cfg_data > FACTOR_HI)
						factor_q <= FACTOR_HI;
					else
						factor_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			action_q  <= '0;
			go_q      <= 1'b0;
			cap_q     <= '0;
			adapted_q <= '0;
			pending_q <= '0;
			peak_q    <= '0;
			lw_q      <= '0;
			waiter_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				action_q <= action;
				go_q     <= need_unit;
			end
			if (state_q == ST_ADAPT && go_q) begin
				if (action_t'(action_q) == ACT_OVERLOAD) begin
					if (ov_nxt < cur_c) begin
						adapted_q <= ov_nxt;
						if (lw_q == '0 || ov_nxt < lw_q)
							lw_q <= ov_nxt;
					end
				end else begin
					adapted_q <= (gr_nxt >= SW'(ceil_c)) ? '0 : CW'(gr_nxt);
				end
			end
			if (state_q == ST_CAP)
				cap_q <= cap_c;
			if (load_out) begin
				pending_q <= pend_n;
				peak_q    <= peak_n;
				waiter_q  <= waiter_n;
			end
			if (load_out)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			admitted     <= adm_n;
			queue_full   <= qfull_n;
			wake_count   <= WAKE_W'(wake_n);
			capacity_now <= FIELD_W'(cap_q);
			pending_now  <= FIELD_W'(pend_n);
			peak_pending <= FIELD_W'(peak_n);
			low_water    <= FIELD_W'(lw_q);
			available    <= FIELD_W'(avail_c);
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the AIMD admission controller core: directed table, then random phases.
module tb;
	import aac_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;
	localparam logic [FIELD_W-1:0]  PEND_MAX   = '1;
	localparam logic [UNITS_W-1:0]  UNITS_MAX  = '1;
	localparam int WAITER_LIMIT = DEF_MAX_WAITERS;
	localparam int MIX_ALL      = 0;
	localparam int MIX_PARK     = 1;
	localparam int CYCLE_LIMIT  = 4_000_000;

	typedef struct packed {
		logic                admitted;
		logic                queue_full;
		logic [WAKE_W-1:0]   wake;
		logic [FIELD_W-1:0]  cap;
		logic [FIELD_W-1:0]  pend;
		logic [FIELD_W-1:0]  peak;
		logic [FIELD_W-1:0]  low;
		logic [FIELD_W-1:0]  avail;
	} status_t;

	typedef struct {
		bit                   is_reg;
		reg_idx_t             idx;
		logic [CFG_DAT_W-1:0] data;
		logic [ACTION_W-1:0]  act;
		logic [UNITS_W-1:0]   amount;
		bit                   known;
		status_t              want;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [ACTION_W-1:0]  action;
	logic [UNITS_W-1:0]   units;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 admitted;
	logic                 queue_full;
	logic [WAKE_W-1:0]    wake_count;
	logic [FIELD_W-1:0]   capacity_now;
	logic [FIELD_W-1:0]   pending_now;
	logic [FIELD_W-1:0]   peak_pending;
	logic [FIELD_W-1:0]   low_water;
	logic [FIELD_W-1:0]   available;

	aimd_admission_controller_core dut (.*);

	// predictor copy of registers and state
	logic [FIELD_W-1:0]  m_ceiling  = '0;
	logic [FIELD_W-1:0]  m_default  = RST_DEFAULT_CAP;
	logic [FIELD_W-1:0]  m_floor    = RST_MIN_FLOOR;
	logic                m_adaptive = 1'b0;
	logic [FACTOR_W-1:0] m_factor   = RST_FACTOR;
	logic [FIELD_W-1:0]  adapted    = '0;
	logic [FIELD_W-1:0]  pend_cnt   = '0;
	logic [FIELD_W-1:0]  peak_cnt   = '0;
	logic [FIELD_W-1:0]  low_mark   = '0;
	logic [WAKE_W-1:0]   waiters    = '0;

	status_t status_due[$];
	row_t    dir_rows[$];
	bit      idle_on = 1'b0;
	int      mismatches = 0;
	int      words = 0;
	int      reg_writes = 0;
	int      refusals = 0;
	int      wake_peak = 0;
	int      stall_left = 0;
	int      cycle_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned ceil_eff();
		longint unsigned c;
		c = (m_ceiling != '0) ? 64'(m_ceiling) : 64'(m_default);
		return (c == 0) ? 1 : c;
	endfunction

	function automatic longint unsigned floor_eff(longint unsigned top);
		longint unsigned f;
		f = (m_floor == '0) ? 64'd1 : 64'(m_floor);
		return (f < top) ? f : top;
	endfunction

	function automatic longint unsigned cap_eff();
		longint unsigned top, fl;
		top = ceil_eff();
		if (!m_adaptive || adapted == '0)
			return top;
		fl = floor_eff(top);
		if (64'(adapted) < fl)
			return fl;
		if (64'(adapted) > top)
			return top;
		return 64'(adapted);
	endfunction

	function automatic status_t apply_action(logic [ACTION_W-1:0] act, logic [UNITS_W-1:0] amount);
		status_t r;
		longint unsigned top, fl, cur, nxt, cap, head, wake;
		r = '0;
		wake = 0;
		case (act)
			ACT_ACQUIRE: begin
				if (pend_cnt < PEND_MAX)
					pend_cnt++;
				if (pend_cnt > peak_cnt)
					peak_cnt = pend_cnt;
			end
			ACT_RELEASE: begin
				if (pend_cnt > 0)
					pend_cnt--;
				if (64'(pend_cnt) < cap_eff() && waiters > 0) begin
					waiters--;
					wake = 1;
				end
			end
			ACT_WAIT: begin
				if (64'(pend_cnt) < cap_eff())
					r.admitted = 1'b1;
				else if (waiters < WAITER_LIMIT)
					waiters++;
				else
					r.queue_full = 1'b1;
			end
			ACT_OVERLOAD: begin
				if (m_adaptive) begin
					top = ceil_eff();
					fl  = floor_eff(top);
					cur = (adapted != '0) ? 64'(adapted) : top;
					nxt = (cur * 64'(m_factor)) >> 16;
					if (nxt < fl)
						nxt = fl;
					if (nxt > top)
						nxt = top;
					if (nxt < cur) begin
						adapted = FIELD_W'(nxt);
						if (low_mark == '0 || nxt < 64'(low_mark))
							low_mark = FIELD_W'(nxt);
					end
				end
			end
			ACT_SUCCESS: begin
				if (amount != '0 && m_adaptive && adapted != '0) begin
					top = ceil_eff();
					nxt = 64'(amount) / 64'(adapted);
					if (nxt < 1)
						nxt = 1;
					nxt = 64'(adapted) + nxt;
					adapted = (nxt >= top) ? '0 : FIELD_W'(nxt);
					cap = cap_eff();
					if (cap > 64'(pend_cnt)) begin
						head = cap - 64'(pend_cnt);
						wake = (head < 64'(waiters)) ? head : 64'(waiters);
						waiters = waiters - WAKE_W'(wake);
					end
				end
			end
			default: ;
		endcase
		cap     = cap_eff();
		r.wake  = WAKE_W'(wake);
		r.cap   = FIELD_W'(cap);
		r.pend  = pend_cnt;
		r.peak  = peak_cnt;
		r.low   = low_mark;
		r.avail = (cap > 64'(pend_cnt)) ? FIELD_W'(cap - 64'(pend_cnt)) : '0;
		if (r.queue_full)
			refusals++;
		if (wake > 64'(wake_peak))
			wake_peak = int'(wake);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_status(status_t want);
		check_field("admitted", 32'(want.admitted), 32'(admitted));
		check_field("queue_full", 32'(want.queue_full), 32'(queue_full));
		check_field("wake_count", 32'(want.wake), 32'(wake_count));
		check_field("capacity_now", 32'(want.cap), 32'(capacity_now));
		check_field("pending_now", 32'(want.pend), 32'(pending_now));
		check_field("peak_pending", 32'(want.peak), 32'(peak_pending));
		check_field("low_water", 32'(want.low), 32'(low_water));
		check_field("available", 32'(want.avail), 32'(available));
	endtask

	// result side
	always @(posedge clk) begin
		status_t want_now;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (status_due.size() == 0) begin
				$error("result word with nothing outstanding");
				mismatches++;
			end else begin
				want_now = status_due[0];
				status_due.delete(0);
				check_status(want_now);
			end
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 7);
		out_stall <= (stall_left > 0);
	end

	task automatic push_word(logic [ACTION_W-1:0] act, logic [UNITS_W-1:0] amount, bit known,
			status_t want);
		status_t got;
		in_valid <= 1'b1;
		action   <= act;
		units    <= amount;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		got = apply_action(act, amount);
		status_due.insert(status_due.size(), known ? want : got);
		words++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CEILING:  m_ceiling  = val;
			REG_DEFAULT:  m_default  = val;
			REG_FLOOR:    m_floor    = val;
			REG_ADAPTIVE: m_adaptive = val[0];
			REG_FACTOR:   m_factor   = (val < FACTOR_LO) ? FACTOR_LO :
				(val > FACTOR_HI) ? FACTOR_HI : val;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic run_phase(int n, int mode);
		logic [ACTION_W-1:0] act;
		logic [UNITS_W-1:0]  amount;
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (mode == MIX_PARK)
				act = (r < 95) ? ACT_WAIT : ACT_ACQUIRE;
			else if (r < 18)
				act = ACT_ACQUIRE;
			else if (r < 36)
				act = ACT_RELEASE;
			else if (r < 56)
				act = ACT_WAIT;
			else if (r < 70)
				act = ACT_OVERLOAD;
			else if (r < 92)
				act = ACT_SUCCESS;
			else if (r < 96)
				act = ACT_STATUS;
			else if (r < 98)
				act = ACT_SPARE6;
			else
				act = ACT_SPARE7;
			r = $urandom_range(0, 9);
			if (act != ACT_SUCCESS || r >= 8)
				amount = $urandom;
			else if (r < 2)
				amount = '0;
			else if (r < 5)
				amount = $urandom_range(1, 8);
			else if (r < 7)
				amount = $urandom_range(9, 300);
			else
				amount = UNITS_MAX;
			push_word(act, amount, 1'b0, '0);
		end
	endtask

	task automatic add_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] val);
		row_t r;
		r = '{is_reg: 1'b1, idx: idx, data: val, act: ACT_STATUS, amount: '0, known: 1'b0,
			want: '0};
		dir_rows.insert(dir_rows.size(), r);
	endtask

	task automatic add_word(logic [ACTION_W-1:0] act, logic [UNITS_W-1:0] amount);
		row_t r;
		r = '{is_reg: 1'b0, idx: REG_CEILING, data: '0, act: act, amount: amount, known: 1'b0,
			want: '0};
		dir_rows.insert(dir_rows.size(), r);
	endtask

	task automatic add_known(logic [ACTION_W-1:0] act, logic [UNITS_W-1:0] amount, status_t want);
		row_t r;
		r = '{is_reg: 1'b0, idx: REG_CEILING, data: '0, act: act, amount: amount, known: 1'b1,
			want: want};
		dir_rows.insert(dir_rows.size(), r);
	endtask

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb failed");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		action    = '0;
		units     = '0;

		// directed table: reset defaults first, typed where obvious
		add_known(ACT_STATUS, '0, {1'b0, 1'b0, 11'd0, 16'd20, 16'd0, 16'd0, 16'd0, 16'd20});
		add_known(ACT_RELEASE, '0, {1'b0, 1'b0, 11'd0, 16'd20, 16'd0, 16'd0, 16'd0, 16'd20});
		add_known(ACT_ACQUIRE, '0, {1'b0, 1'b0, 11'd0, 16'd20, 16'd1, 16'd1, 16'd0, 16'd19});
		add_known(ACT_WAIT, '0, {1'b1, 1'b0, 11'd0, 16'd20, 16'd1, 16'd1, 16'd0, 16'd19});
		// adaptation off: overload and success leave everything alone
		add_known(ACT_OVERLOAD, UNITS_MAX, {1'b0, 1'b0, 11'd0, 16'd20, 16'd1, 16'd1, 16'd0, 16'd19});
		add_known(ACT_SUCCESS, UNITS_MAX, {1'b0, 1'b0, 11'd0, 16'd20, 16'd1, 16'd1, 16'd0, 16'd19});
		add_known(ACT_SPARE6, UNITS_MAX, {1'b0, 1'b0, 11'd0, 16'd20, 16'd1, 16'd1, 16'd0, 16'd19});
		add_known(ACT_SPARE7, '0, {1'b0, 1'b0, 11'd0, 16'd20, 16'd1, 16'd1, 16'd0, 16'd19});
		add_reg(REG_ADAPTIVE, 16'd1);
		add_reg(REG_CEILING, 16'd10);
		add_word(ACT_OVERLOAD, '0);
		add_word(ACT_SUCCESS, '0);
		add_reg(REG_FACTOR, 16'd0);            // clamps to the low factor
		add_word(ACT_OVERLOAD, '0);            // product truncates below floor
		add_word(ACT_WAIT, '0);
		add_word(ACT_WAIT, '0);
		add_word(ACT_SUCCESS, 32'd1);
		add_word(ACT_RELEASE, '0);
		add_word(ACT_SUCCESS, UNITS_MAX);      // reaches ceiling, adapted value cleared
		add_reg(REG_FACTOR, 16'hFFFF);         // clamps to the high factor
		add_reg(REG_FLOOR, 16'd0);
		add_word(ACT_OVERLOAD, '0);
		add_reg(REG_FLOOR, 16'hFFFF);          // floor pinned to ceiling
		add_word(ACT_STATUS, '0);
		add_word(ACT_OVERLOAD, '0);            // no decrease, nothing stored
		add_reg(REG_CEILING, 16'd0);
		add_reg(REG_DEFAULT, 16'd0);           // zero ceiling and default: ceiling of one
		add_word(ACT_STATUS, '0);
		add_word(ACT_WAIT, '0);
		add_word(ACT_ACQUIRE, '0);
		add_word(ACT_WAIT, '0);
		add_word(ACT_SUCCESS, 32'd5);
		add_reg(REG_DEFAULT, RST_DEFAULT_CAP);
		add_reg(REG_FLOOR, RST_MIN_FLOOR);
		add_reg(REG_FACTOR, RST_FACTOR);
		add_reg(REG_ADAPTIVE, 16'd0);
		add_word(ACT_RELEASE, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				push_word(dir_rows[i].act, dir_rows[i].amount, dir_rows[i].known,
					dir_rows[i].want);
		end

		idle_on = 1'b1;
		write_reg(REG_CEILING, 16'd8);
		write_reg(REG_FLOOR, 16'd2);
		write_reg(REG_ADAPTIVE, 16'd1);
		run_phase(150, MIX_ALL);

		write_reg(REG_CEILING, 16'd0);
		write_reg(REG_DEFAULT, CFG_DAT_W'($urandom_range(1, 64)));
		write_reg(REG_FLOOR, CFG_DAT_W'($urandom_range(0, 10)));
		write_reg(REG_FACTOR, CFG_DAT_W'($urandom_range(0, 65535)));
		run_phase(150, MIX_ALL);

		write_reg(REG_CEILING, 16'hFFFF);
		write_reg(REG_FLOOR, 16'd1);
		write_reg(REG_FACTOR, CFG_DAT_W'($urandom_range(64880, 65535)));
		run_phase(100, MIX_ALL);

		write_reg(REG_CEILING, CFG_DAT_W'($urandom_range(1, 40)));
		write_reg(REG_DEFAULT, 16'd0);
		write_reg(REG_FLOOR, 16'hFFFF);
		write_reg(REG_FACTOR, 16'd0);
		run_phase(100, MIX_ALL);

		write_reg(REG_ADAPTIVE, 16'd0);
		write_reg(REG_CEILING, 16'd3);
		write_reg(REG_DEFAULT, 16'hFFFF);
		run_phase(80, MIX_ALL);

		// park waiters behind a ceiling of one until the counter is full
		write_reg(REG_CEILING, 16'd1);
		push_word(ACT_ACQUIRE, $urandom, 1'b0, '0);
		push_word(ACT_ACQUIRE, $urandom, 1'b0, '0);
		run_phase(1100, MIX_PARK);

		// open the gate wide so one success wakes the whole queue
		write_reg(REG_CEILING, 16'hFFFF);
		write_reg(REG_FLOOR, 16'd1);
		write_reg(REG_FACTOR, RST_FACTOR);
		write_reg(REG_ADAPTIVE, 16'd1);
		push_word(ACT_SUCCESS, UNITS_MAX, 1'b0, '0);
		push_word(ACT_OVERLOAD, '0, 1'b0, '0);
		push_word(ACT_SUCCESS, 32'd1, 1'b0, '0);
		run_phase(100, MIX_ALL);

		// last part: no idling; a run of back to back acquires, then a wait and a release
		idle_on = 1'b0;
		write_reg(REG_ADAPTIVE, 16'd0);
		write_reg(REG_CEILING, 16'd0);
		write_reg(REG_DEFAULT, RST_DEFAULT_CAP);
		repeat (24) push_word(ACT_ACQUIRE, $urandom, 1'b0, '0);
		push_word(ACT_WAIT, '0, 1'b0, '0);
		push_word(ACT_RELEASE, '0, 1'b0, '0);
		write_reg(REG_ADAPTIVE, 16'd1);
		write_reg(REG_CEILING, 16'hFFFF);
		run_phase(100, MIX_ALL);

		settle();
		repeat (60) @(posedge clk);
		$display("run covered %0d words and %0d register writes in %0d cycles",
			words, reg_writes, cycle_cnt);
		$display("largest wake %0d, refused waits %0d, peak pending %0d",
			wake_peak, refusals, peak_cnt);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
